// ----- rtl/edf_pkg.sv -----
package edf_pkg;

  // Layout of one task parameter word.
  localparam int PARAM_BITS   = 48;
  localparam int FIELD_BITS   = 16;
  localparam int PERIOD_LSB   = 0;
  localparam int BUDGET_LSB   = 16;
  localparam int DEADLINE_LSB = 32;

  // Port widths fixed by the register map and the result format.
  localparam int TASK_COUNT_BITS = 3;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int RUN_BITS        = 3;
  localparam int MASK_BITS       = 4;

  // Register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_TASK_COUNT        = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TASK_PARAMS_FIRST = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TASK_PARAMS_LAST  = 3'd4;

  // Reset value of the task count register.
  localparam logic [TASK_COUNT_BITS-1:0] TASK_COUNT_RESET = 3'd4;

  // Tick sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } seq_state_t;

  // Control from the sequencer to the per-task state file.
  typedef struct packed {
    logic clear;      // return all task state to reset values
    logic scan_wr;    // write back release and aging for the scanned task
    logic finish_wr;  // charge one tick of budget to the chosen task
  } tf_ctrl_t;

  // Control from the sequencer to the deadline compare unit.
  typedef struct packed {
    logic start;  // forget the current best candidate
    logic step;   // offer the scanned task as a candidate
  } sel_ctrl_t;

  // Extract one 16-bit field of a parameter word.
  function automatic logic [FIELD_BITS-1:0] param_field(
    input logic [PARAM_BITS-1:0] word,
    input int                    lsb
  );
    return word[lsb +: FIELD_BITS];
  endfunction

endpackage

// ----- rtl/edf_tick_scheduler_core.sv -----
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall   restart
// out       source     out_valid / out_stall running_task, released_mask
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each tick takes the beat; the sequencer then walks the task file, task by task,
// through the shared deadline comparator, and finally charges the winner and loads
// the result into the output register.
// Reset and restart clear all task state at once; configuration is kept on restart.
// A stalled result holds the sequencer in its last step; no new tick is taken
// until the result is loaded into the output register.
module edf_tick_scheduler_core #(
  parameter int NUM_TASKS = 4,
  parameter int TIME_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [edf_pkg::RUN_BITS-1:0]        running_task,
  output logic [edf_pkg::MASK_BITS-1:0]       released_mask,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [edf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [edf_pkg::PARAM_BITS-1:0]      cfg_data
);

  localparam int IDX_BITS = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(NUM_TASKS - 1);

  edf_pkg::seq_state_t state, state_next;
  edf_pkg::tf_ctrl_t   tf_ctrl;
  edf_pkg::sel_ctrl_t  sel_ctrl;

  logic [IDX_BITS-1:0]                 scan_idx, scan_idx_next;
  logic [IDX_BITS-1:0]                 tf_idx;
  logic [edf_pkg::MASK_BITS-1:0]       mask, mask_next;
  logic                                in_take;
  logic                                out_load;
  logic                                out_free;
  logic [edf_pkg::TASK_COUNT_BITS-1:0] task_count;
  logic [edf_pkg::PARAM_BITS-1:0]      task_params;
  logic                                released;
  logic                                eligible;
  logic signed [TIME_BITS:0]           cand_deadline;
  logic                                found;
  logic [IDX_BITS-1:0]                 best_idx;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != edf_pkg::ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // The task file is addressed by the scan, then by the winner.
  assign tf_idx = (state == edf_pkg::ST_FINISH) ? best_idx : scan_idx;

  edf_cfg_regs #(
    .NUM_TASKS (NUM_TASKS),
    .IDX_BITS  (IDX_BITS)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (cfg_valid && cfg_ready),
    .wr_index   (cfg_index),
    .wr_data    (cfg_data),
    .rd_idx     (scan_idx),
    .task_count (task_count),
    .rd_params  (task_params)
  );

  edf_task_file #(
    .NUM_TASKS (NUM_TASKS),
    .TIME_BITS (TIME_BITS),
    .IDX_BITS  (IDX_BITS)
  ) u_tasks (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (tf_ctrl),
    .idx           (tf_idx),
    .params        (task_params),
    .task_count    (task_count),
    .released      (released),
    .eligible      (eligible),
    .cand_deadline (cand_deadline)
  );

  edf_select_unit #(
    .TIME_BITS (TIME_BITS),
    .IDX_BITS  (IDX_BITS)
  ) u_select (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (sel_ctrl),
    .idx      (scan_idx),
    .eligible (eligible),
    .deadline (cand_deadline),
    .found    (found),
    .best_idx (best_idx)
  );

  // Sequencer state and scan registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= edf_pkg::ST_IDLE;
      scan_idx <= '0;
      mask     <= '0;
    end else begin
      state    <= state_next;
      scan_idx <= scan_idx_next;
      mask     <= mask_next;
    end
  end

  // Next state and control for each step of a tick.
  always_comb begin
    state_next       = state;
    scan_idx_next    = scan_idx;
    mask_next        = mask;
    tf_ctrl          = '0;
    sel_ctrl         = '0;
    out_load         = 1'b0;
    case (state)
      edf_pkg::ST_IDLE: begin
        if (in_take) begin
          tf_ctrl.clear  = restart;
          sel_ctrl.start = 1'b1;
          scan_idx_next  = '0;
          mask_next      = '0;
          state_next     = edf_pkg::ST_SCAN;
        end
      end
      edf_pkg::ST_SCAN: begin
        tf_ctrl.scan_wr = 1'b1;
        sel_ctrl.step   = 1'b1;
        for (int b = 0; b < edf_pkg::MASK_BITS; b++) begin
          if (released && (32'(scan_idx) == b)) begin
            mask_next[b] = 1'b1;
          end
        end
        if (scan_idx == LAST_IDX) begin
          state_next = edf_pkg::ST_FINISH;
        end else begin
          scan_idx_next = scan_idx + IDX_BITS'(1);
        end
      end
      edf_pkg::ST_FINISH: begin
        if (out_free) begin
          tf_ctrl.finish_wr = found;
          out_load          = 1'b1;
          state_next        = edf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = edf_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register for the result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      running_task  <= found ? edf_pkg::RUN_BITS'(32'(best_idx) + 1) : '0;
      released_mask <= mask;
    end
  end

endmodule

// ----- rtl/edf_cfg_regs.sv -----
module edf_cfg_regs #(
  parameter int NUM_TASKS = 4,
  parameter int IDX_BITS  = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [edf_pkg::CFG_INDEX_BITS-1:0]   wr_index,
  input  logic [edf_pkg::PARAM_BITS-1:0]       wr_data,
  input  logic [IDX_BITS-1:0]                  rd_idx,
  output logic [edf_pkg::TASK_COUNT_BITS-1:0]  task_count,
  output logic [edf_pkg::PARAM_BITS-1:0]       rd_params
);

  logic [edf_pkg::PARAM_BITS-1:0]      params [NUM_TASKS];
  logic [edf_pkg::CFG_INDEX_BITS-1:0]  slot;
  logic                                is_param_reg;

  // Parameter registers start at index one; slot zero is task 0.
  assign slot = wr_index - edf_pkg::REG_TASK_PARAMS_FIRST;
  assign is_param_reg = (wr_index >= edf_pkg::REG_TASK_PARAMS_FIRST) &&
                        (wr_index <= edf_pkg::REG_TASK_PARAMS_LAST);

  // Register writes. Slots without a register keep all-zero parameters.
  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= edf_pkg::TASK_COUNT_RESET;
      for (int t = 0; t < NUM_TASKS; t++) begin
        params[t] <= '0;
      end
    end else if (wr_en) begin
      if (wr_index == edf_pkg::REG_TASK_COUNT) begin
        task_count <= wr_data[edf_pkg::TASK_COUNT_BITS-1:0];
      end
      for (int t = 0; t < NUM_TASKS; t++) begin
        if (is_param_reg && (32'(slot) == t)) begin
          params[t] <= wr_data;
        end
      end
    end
  end

  // Single read port for the scanned task.
  assign rd_params = params[rd_idx];

endmodule

// ----- rtl/edf_task_file.sv -----
module edf_task_file #(
  parameter int NUM_TASKS = 4,
  parameter int TIME_BITS = 16,
  parameter int IDX_BITS  = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  edf_pkg::tf_ctrl_t                    ctrl,
  input  logic [IDX_BITS-1:0]                  idx,
  input  logic [edf_pkg::PARAM_BITS-1:0]       params,
  input  logic [edf_pkg::TASK_COUNT_BITS-1:0]  task_count,
  output logic                                 released,
  output logic                                 eligible,
  output logic signed [TIME_BITS:0]            cand_deadline
);

  localparam logic signed [TIME_BITS:0] DL_MAX = {1'b0, {TIME_BITS{1'b1}}};
  localparam logic signed [TIME_BITS:0] DL_MIN = {1'b1, {TIME_BITS{1'b0}}};

  logic [TIME_BITS-1:0]        countdown [NUM_TASKS];
  logic [TIME_BITS-1:0]        budget    [NUM_TASKS];
  logic signed [TIME_BITS:0]   deadline  [NUM_TASKS];

  logic [TIME_BITS-1:0]        period;
  logic [TIME_BITS-1:0]        budget_init;
  logic signed [TIME_BITS:0]   deadline_init;
  logic                        enabled;
  logic [TIME_BITS-1:0]        cd_rel;
  logic [TIME_BITS-1:0]        bud_rel;
  logic signed [TIME_BITS:0]   dl_rel;
  logic [TIME_BITS-1:0]        cd_next;
  logic signed [TIME_BITS:0]   dl_next;
  logic [TIME_BITS-1:0]        bud_charged;

  // Parameter fields, reduced to the time width.
  assign period        = TIME_BITS'(edf_pkg::param_field(params, edf_pkg::PERIOD_LSB));
  assign budget_init   = TIME_BITS'(edf_pkg::param_field(params, edf_pkg::BUDGET_LSB));
  assign deadline_init = (TIME_BITS + 1)'(
                           TIME_BITS'(edf_pkg::param_field(params, edf_pkg::DEADLINE_LSB)));

  // A task is live when its slot is below the task count and its period is set.
  assign enabled  = (32'(idx) < 32'(task_count)) && (period != '0);
  assign released = enabled && (countdown[idx] == '0);

  // State of the scanned task after a possible release.
  assign cd_rel  = released ? period        : countdown[idx];
  assign bud_rel = released ? budget_init   : budget[idx];
  assign dl_rel  = released ? deadline_init : deadline[idx];

  assign eligible      = enabled && (bud_rel != '0);
  assign cand_deadline = dl_rel;

  // Aging for the scan write-back; the deadline saturates at its lower bound.
  assign cd_next     = cd_rel - TIME_BITS'(cd_rel != '0);
  assign dl_next     = (dl_rel != DL_MIN) ? dl_rel - (TIME_BITS + 1)'(1) : dl_rel;
  assign bud_charged = budget[idx] - TIME_BITS'(1);

  // Per-task state: one entry written per cycle, all cleared on restart.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int t = 0; t < NUM_TASKS; t++) begin
        countdown[t] <= '0;
        budget[t]    <= '0;
        deadline[t]  <= DL_MAX;
      end
    end else begin
      for (int t = 0; t < NUM_TASKS; t++) begin
        if (32'(idx) == t) begin
          if (ctrl.scan_wr && enabled) begin
            countdown[t] <= cd_next;
            budget[t]    <= bud_rel;
            deadline[t]  <= dl_next;
          end else if (ctrl.finish_wr) begin
            budget[t] <= bud_charged;
          end
        end
      end
    end
  end

endmodule

// ----- rtl/edf_select_unit.sv -----
module edf_select_unit #(
  parameter int TIME_BITS = 16,
  parameter int IDX_BITS  = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  edf_pkg::sel_ctrl_t          ctrl,
  input  logic [IDX_BITS-1:0]         idx,
  input  logic                        eligible,
  input  logic signed [TIME_BITS:0]   deadline,
  output logic                        found,
  output logic [IDX_BITS-1:0]         best_idx
);

  logic signed [TIME_BITS:0] best_deadline;
  logic                      earlier;

  // Shared comparator: strictly earlier wins, so ties keep the lower index.
  assign earlier = !found || (deadline < best_deadline);

  // Running best candidate over the scan.
  always_ff @(posedge clk) begin
    if (rst || ctrl.start) begin
      found <= 1'b0;
    end else if (ctrl.step && eligible && earlier) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step && eligible && earlier) begin
      best_idx      <= idx;
      best_deadline <= deadline;
    end
  end

endmodule

// ----- tb/edf_tick_scheduler_core_test.sv -----
module edf_tick_scheduler_core_test;

  localparam int NTASK        = 4;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TARGET_TICKS = 1900;
  localparam int HOLD_CYCLES  = 200;

  // Register indexes past the last task slot; writes there must be ignored.
  localparam logic [edf_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED_FIRST =
    edf_pkg::REG_TASK_PARAMS_LAST + 3'd1;
  localparam logic [edf_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED_LAST  = 3'd7;

  // Deadline bounds of the 17-bit signed relative deadline.
  localparam logic signed [edf_pkg::FIELD_BITS:0] DL_CEIL  = 17'sh0FFFF;
  localparam logic signed [edf_pkg::FIELD_BITS:0] DL_FLOOR = 17'sh10000;

  typedef struct packed {
    logic [edf_pkg::RUN_BITS-1:0]  run;
    logic [edf_pkg::MASK_BITS-1:0] mask;
  } tick_result_t;

  // Schedule predictor and the queue of ticks it has worked out.
  class tick_scoreboard;
    logic [edf_pkg::TASK_COUNT_BITS-1:0] task_count;
    logic [edf_pkg::PARAM_BITS-1:0]      params[NTASK];
    logic [edf_pkg::FIELD_BITS-1:0]      countdown[NTASK];
    logic [edf_pkg::FIELD_BITS-1:0]      budget_left[NTASK];
    logic signed [edf_pkg::FIELD_BITS:0] dl_left[NTASK];
    tick_result_t                        predicted_ticks[$];
    int                                  errors;
    int                                  checked;
    int                                  restarts;

    function new();
      task_count = edf_pkg::TASK_COUNT_RESET;
      foreach (params[i]) params[i] = '0;
      errors   = 0;
      checked  = 0;
      restarts = 0;
      clear_state();
    endfunction

    function void clear_state();
      for (int i = 0; i < NTASK; i++) begin
        countdown[i]   = '0;
        budget_left[i] = '0;
        dl_left[i]     = DL_CEIL;
      end
    endfunction

    function void apply_reg(logic [edf_pkg::CFG_INDEX_BITS-1:0] idx,
                            logic [edf_pkg::PARAM_BITS-1:0] data);
      if (idx == edf_pkg::REG_TASK_COUNT) begin
        task_count = data[edf_pkg::TASK_COUNT_BITS-1:0];
      end else if (idx >= edf_pkg::REG_TASK_PARAMS_FIRST &&
                   idx <= edf_pkg::REG_TASK_PARAMS_LAST) begin
        params[2'(idx - edf_pkg::REG_TASK_PARAMS_FIRST)] = data;
      end
    endfunction

    function int pending();
      return predicted_ticks.size();
    endfunction

    // Release, pick the earliest deadline, charge it, then age every enabled task.
    function void advance_schedule(logic restart_bit);
      bit                             enabled[NTASK];
      int                             limit;
      int                             chosen;
      logic [edf_pkg::FIELD_BITS-1:0] period;
      tick_result_t                   res;
      if (restart_bit) begin
        clear_state();
        restarts++;
      end
      limit    = (task_count > NTASK) ? NTASK : int'(task_count);
      res.mask = '0;
      for (int i = 0; i < NTASK; i++) begin
        period     = params[i][edf_pkg::PERIOD_LSB +: edf_pkg::FIELD_BITS];
        enabled[i] = (i < limit) && (period != 0);
        if (enabled[i] && countdown[i] == 0) begin
          budget_left[i] = params[i][edf_pkg::BUDGET_LSB +: edf_pkg::FIELD_BITS];
          dl_left[i]     = $signed({1'b0,
                                    params[i][edf_pkg::DEADLINE_LSB +: edf_pkg::FIELD_BITS]});
          countdown[i]   = period;
          res.mask[i]    = 1'b1;
        end
      end
      chosen = -1;
      for (int i = 0; i < NTASK; i++) begin
        if (enabled[i] && budget_left[i] != 0) begin
          if (chosen < 0 || dl_left[i] < dl_left[chosen]) chosen = i;
        end
      end
      if (chosen >= 0) budget_left[chosen] = budget_left[chosen] - 1'b1;
      for (int i = 0; i < NTASK; i++) begin
        if (enabled[i]) begin
          if (countdown[i] != 0) countdown[i] = countdown[i] - 1'b1;
          if (dl_left[i] > DL_FLOOR) dl_left[i] = dl_left[i] - (edf_pkg::FIELD_BITS + 1)'(1);
        end
      end
      res.run = edf_pkg::RUN_BITS'(chosen + 1);
      predicted_ticks.push_back(res);
    endfunction

    // Compare one result beat against the oldest predicted tick.
    function void check_tick(logic [edf_pkg::RUN_BITS-1:0] run,
                             logic [edf_pkg::MASK_BITS-1:0] mask);
      tick_result_t exp_res;
      if (predicted_ticks.size() == 0) begin
        $error("result beat with no tick pending: running_task %0d released_mask %0h",
               run, mask);
        errors++;
        return;
      end
      exp_res = predicted_ticks.pop_front();
      checked++;
      if (run !== exp_res.run) begin
        $error("running_task: expected %0d, actual %0d", exp_res.run, run);
        errors++;
      end
      if (mask !== exp_res.mask) begin
        $error("released_mask: expected %0h, actual %0h", exp_res.mask, mask);
        errors++;
      end
    endfunction
  endclass

  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_stall;
  logic                                restart;
  logic                                out_valid;
  logic                                out_stall;
  logic [edf_pkg::RUN_BITS-1:0]        running_task;
  logic [edf_pkg::MASK_BITS-1:0]       released_mask;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [edf_pkg::CFG_INDEX_BITS-1:0]  cfg_index;
  logic [edf_pkg::PARAM_BITS-1:0]      cfg_data;

  tick_scoreboard sb = new();

  bit tx_gaps;
  bit rx_stalls;
  bit hold_req;
  int ticks_sent;
  int cfg_writes;
  int settings;
  int idle_cycles;

  edf_tick_scheduler_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .running_task (running_task),
    .released_mask(released_mask),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver: random stalls, or a long counted hold-off once it is requested.
  initial begin
    int hold_left;
    bit hold_taken;
    out_stall  = 1'b0;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (rx_stalls) begin
        out_stall = ($urandom_range(99) < 25);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Check every accepted result beat.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_tick(running_task, released_mask);
  end

  // Watchdog on cycles in which no channel moves a beat.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [edf_pkg::PARAM_BITS-1:0] make_params(
    logic [edf_pkg::FIELD_BITS-1:0] period,
    logic [edf_pkg::FIELD_BITS-1:0] budget,
    logic [edf_pkg::FIELD_BITS-1:0] deadline
  );
    return {deadline, budget, period};
  endfunction

  // Mostly short periods so that jobs overlap; now and then extremes or noise.
  function automatic logic [edf_pkg::PARAM_BITS-1:0] rand_params();
    logic [edf_pkg::FIELD_BITS-1:0] f[3];
    case ($urandom_range(9))
      0: return edf_pkg::PARAM_BITS'({$urandom, $urandom});
      1: begin
        foreach (f[i]) begin
          case ($urandom_range(2))
            0:       f[i] = '0;
            1:       f[i] = 16'd1;
            default: f[i] = '1;
          endcase
        end
        return make_params(f[0], f[1], f[2]);
      end
      default: return make_params(edf_pkg::FIELD_BITS'($urandom_range(12, 0)),
                                  edf_pkg::FIELD_BITS'($urandom_range(4, 0)),
                                  edf_pkg::FIELD_BITS'($urandom_range(14, 0)));
    endcase
  endfunction

  function automatic logic [edf_pkg::TASK_COUNT_BITS-1:0] rand_task_count();
    case ($urandom_range(9))
      0:       return '0;
      1:       return edf_pkg::TASK_COUNT_BITS'($urandom_range(7, 5));
      default: return edf_pkg::TASK_COUNT_BITS'($urandom_range(4, 1));
    endcase
  endfunction

  task automatic send_tick(input logic rs);
    while (tx_gaps && $urandom_range(99) < 25) begin
      @(negedge clk);
      in_valid = 1'b0;
      restart  = $urandom_range(1);
    end
    @(negedge clk);
    in_valid = 1'b1;
    restart  = rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.advance_schedule(rs);
    ticks_sent++;
  endtask

  task automatic cfg_write(input logic [edf_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [edf_pkg::PARAM_BITS-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_reg(idx, data);
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stop offering ticks and wait for every predicted result, plus a margin.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_ticks(input int n);
    for (int k = 0; k < n; k++) send_tick(1'b0);
  endtask

  task automatic randomize_setting();
    logic [edf_pkg::CFG_INDEX_BITS-1:0] idx;
    if ($urandom_range(3) != 0) begin
      cfg_write(edf_pkg::REG_TASK_COUNT, edf_pkg::PARAM_BITS'(rand_task_count()));
    end
    for (int t = 0; t < NTASK; t++) begin
      idx = edf_pkg::CFG_INDEX_BITS'(edf_pkg::REG_TASK_PARAMS_FIRST + t);
      if ($urandom_range(3) != 0) cfg_write(idx, rand_params());
    end
    if ($urandom_range(9) == 0) begin
      cfg_write(edf_pkg::CFG_INDEX_BITS'($urandom_range(REG_UNUSED_LAST, REG_UNUSED_FIRST)),
                edf_pkg::PARAM_BITS'({$urandom, $urandom}));
    end
    settings++;
  endtask

  initial begin
    int phase;
    int phase_len;
    rst        = 1'b1;
    in_valid   = 1'b0;
    restart    = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    tx_gaps    = 1'b0;
    rx_stalls  = 1'b0;
    hold_req   = 1'b0;
    ticks_sent = 0;
    cfg_writes = 0;
    settings   = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset setting: all periods zero, so every tick is idle.
    send_ticks(2);
    settle();

    // Tie between tasks 0 and 1, an all-ones task, and a zero-budget task.
    cfg_write(edf_pkg::REG_TASK_COUNT, edf_pkg::PARAM_BITS'(3'd4));
    cfg_write(edf_pkg::REG_TASK_PARAMS_FIRST, make_params(16'd4, 16'd1, 16'd3));
    cfg_write(edf_pkg::CFG_INDEX_BITS'(edf_pkg::REG_TASK_PARAMS_FIRST + 1),
              make_params(16'd4, 16'd1, 16'd3));
    cfg_write(edf_pkg::CFG_INDEX_BITS'(edf_pkg::REG_TASK_PARAMS_FIRST + 2),
              make_params('1, '1, '1));
    cfg_write(edf_pkg::REG_TASK_PARAMS_LAST, make_params(16'd1, 16'd0, 16'd0));
    for (int r = REG_UNUSED_FIRST; r <= REG_UNUSED_LAST; r++) begin
      cfg_write(edf_pkg::CFG_INDEX_BITS'(r), '1);
    end
    settings++;
    send_ticks(4);
    send_tick(1'b1);
    send_ticks(3);
    settle();

    // No task in use, then a count above the number of slots.
    cfg_write(edf_pkg::REG_TASK_COUNT, edf_pkg::PARAM_BITS'(3'd0));
    send_ticks(2);
    settle();
    cfg_write(edf_pkg::REG_TASK_COUNT, edf_pkg::PARAM_BITS'(3'd7));
    send_ticks(3);
    settle();

    // Disabled slots keep their state frozen until they come back.
    cfg_write(edf_pkg::REG_TASK_COUNT, edf_pkg::PARAM_BITS'(3'd1));
    send_ticks(2);
    settle();
    cfg_write(edf_pkg::REG_TASK_COUNT, edf_pkg::PARAM_BITS'(3'd4));
    send_ticks(2);
    settle();
    cfg_write(edf_pkg::REG_TASK_PARAMS_FIRST, '1);
    send_ticks(2);
    settle();
    settings += 5;

    // Random phases, each with a fresh setting and its own idling mode.
    phase = 0;
    while (ticks_sent < TARGET_TICKS) begin
      randomize_setting();
      phase_len = $urandom_range(120, 40);
      if (phase == 0) begin
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        phase_len = 200;
      end else if (phase == 1) begin
        tx_gaps   = 1'b0;
        rx_stalls = 1'b1;
      end else begin
        tx_gaps   = ($urandom_range(3) != 0);
        rx_stalls = ($urandom_range(3) != 0);
      end
      for (int k = 0; k < phase_len; k++) begin
        if (phase == 1 && k == 10) hold_req = 1'b1;
        if (phase == 2 && k == phase_len / 2) settle();
        send_tick($urandom_range(99) < 3);
      end
      settle();
      phase++;
    end

    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    settle();
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d predicted ticks never came out", sb.pending());
      sb.errors++;
    end
    $display("Covered %0d ticks (%0d restarts) over %0d register settings, %0d config writes.",
             ticks_sent, sb.restarts, settings, cfg_writes);
    $display("Checked %0d result beats with %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/edf_pkg.sv
rtl/edf_cfg_regs.sv
rtl/edf_task_file.sv
rtl/edf_select_unit.sv
rtl/edf_tick_scheduler_core.sv
tb/edf_tick_scheduler_core_test.sv
